@@ rtl/point_in_polygon_test_core_assert.svh @@
// assertion macros for the point in polygon test core
`ifndef POINT_IN_POLYGON_TEST_CORE_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PIPT_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("pipt assertion failed");
`define PIPT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pipt assertion failed");
`else
`define PIPT_ASSERT(label, cond)
`define PIPT_ASSERT_IMP(label, ante, cons)
`endif

`endif

@@ rtl/pipt_pkg.sv @@
// shared constants and types of the point in polygon test core
`default_nettype none
package pipt_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_BITS_DEF = 16;
  localparam int IDX_BITS_DEF = $clog2(MAX_VERTICES_DEF);
  localparam int CNT_BITS_DEF = $clog2(MAX_VERTICES_DEF + 1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic clear;
    logic vld;
    logic first;
  } pipt_edge_ctl_t;

  typedef struct packed {
    logic busy;
    logic odd;
  } pipt_edge_stat_t;

endpackage
`default_nettype wire

@@ rtl/pipt_if.sv @@
// handshake channels of the point in polygon test core
`default_nettype none
interface pipt_item_if #(
  parameter int IDX_BITS = pipt_pkg::IDX_BITS_DEF,
  parameter int COORD_BITS = pipt_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [IDX_BITS-1:0]          vertex_index;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;

  modport source (output valid, operation, vertex_index, coord_x, coord_y, input ready);
  modport sink (input valid, operation, vertex_index, coord_x, coord_y, output ready);
endinterface

interface pipt_res_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

interface pipt_cfg_if #(
  parameter int CNT_BITS = pipt_pkg::CNT_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [CNT_BITS-1:0] vertex_count;

  modport source (output valid, vertex_count, input ready);
  modport sink (input valid, vertex_count, output ready);
endinterface
`default_nettype wire

@@ rtl/pipt_vertex_mem.sv @@
// vertex store, one write and one registered read port
`default_nettype none
module pipt_vertex_mem #(
  parameter int DEPTH = pipt_pkg::MAX_VERTICES_DEF,
  parameter int WIDTH = 2 * pipt_pkg::COORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

@@ rtl/pipt_edge_unit.sv @@
// edge crossing pipeline: ordering and spans, cross products, compare and parity
`default_nettype none
module pipt_edge_unit #(
  parameter int COORD_BITS = pipt_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pipt_pkg::pipt_edge_ctl_t     ctl,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic signed [COORD_BITS-1:0] rd_x,
  input  logic signed [COORD_BITS-1:0] rd_y,
  output pipt_pkg::pipt_edge_stat_t    stat
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic signed [COORD_BITS-1:0] prev_x;
  logic signed [COORD_BITS-1:0] prev_y;

  logic signed [COORD_BITS-1:0] xlo, ylo, xup, yup;
  logic                         span;

  logic                 a_vld;
  logic signed [DW-1:0] dxp, dy, dxe, dyp;
  logic                 b_vld;
  logic signed [PW-1:0] lhs, rhs;
  logic                 parity;

  // orient the edge so that its y grows from lo to up
  always_comb begin
    if (rd_y <= prev_y) begin
      xlo = rd_x;
      ylo = rd_y;
      xup = prev_x;
      yup = prev_y;
    end else begin
      xlo = prev_x;
      ylo = prev_y;
      xup = rd_x;
      yup = rd_y;
    end
    span = (ylo <= py) && (py < yup);
  end

  always_ff @(posedge clk) begin
    if (ctl.vld) begin
      prev_x <= rd_x;
      prev_y <= rd_y;
    end
    dxp <= DW'(px) - DW'(xlo);
    dy  <= DW'(yup) - DW'(ylo);
    dxe <= DW'(xup) - DW'(xlo);
    dyp <= DW'(py) - DW'(ylo);
    lhs <= PW'(dxp) * PW'(dy);
    rhs <= PW'(dxe) * PW'(dyp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld  <= 1'b0;
      b_vld  <= 1'b0;
      parity <= 1'b0;
    end else begin
      a_vld <= ctl.vld && !ctl.first && span;
      b_vld <= a_vld;
      if (ctl.clear) begin
        parity <= 1'b0;
      end else if (b_vld && (lhs < rhs)) begin
        parity <= !parity;
      end
    end
  end

  assign stat.busy = a_vld | b_vld;
  assign stat.odd  = parity;

endmodule
`default_nettype wire

@@ rtl/point_in_polygon_test_core.sv @@
// point in polygon test core: even-odd ray casting over a stored polygon
//
// channels: item (sink) carries operation, vertex_index, coord_x, coord_y;
// res (source) carries inside_res; cfg (sink) writes vertex_count.
// a write word stores one vertex and gives no result; a query word gives
// one result word, 1 when the point is inside by the even-odd rule.
// a query reads the last vertex and then every vertex from index 0 through
// the store's single read port, one edge per read after the first, and
// waits for the edge pipeline to drain before the result word; with
// vertex_count 0 it goes straight to the result step and gives 0.
// one item is worked at a time; item.ready is high while the core is idle.
// the result sits in an output register, so a write word may be accepted
// while the result still waits; a stalled receiver holds the next query in
// its final step until the output register frees. vertex_count above the
// store depth saturates to the depth; cfg.ready is always high and the
// user must write cfg only while the core is idle; the core does not enforce
// it. reset clears vertex_count, the control state and the output valid; the
// vertex store is not cleared and entries must be written before use.
`default_nettype none
`include "point_in_polygon_test_core_assert.svh"
module point_in_polygon_test_core #(
  parameter int MAX_VERTICES = pipt_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS = pipt_pkg::COORD_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  pipt_item_if.sink  item,
  pipt_res_if.source res,
  pipt_cfg_if.sink   cfg
);

  localparam int IDX_BITS = $clog2(MAX_VERTICES);
  localparam int CNT_BITS = $clog2(MAX_VERTICES + 1);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_FIN} state_t;

  state_t state;

  logic [CNT_BITS-1:0]          vertex_count;
  logic [CNT_BITS-1:0]          cnt_m1;
  logic [IDX_BITS-1:0]          last_addr;
  logic [IDX_BITS-1:0]          raddr;
  logic                         rfirst;
  logic                         rdv;
  logic                         rdf;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;

  logic                         in_acc;
  logic                         wr_en;
  logic [2*COORD_BITS-1:0]      rd_data;

  pipt_pkg::pipt_edge_ctl_t     ectl;
  pipt_pkg::pipt_edge_stat_t    estat;

  assign cnt_m1    = vertex_count - CNT_BITS'(1);
  assign last_addr = cnt_m1[IDX_BITS-1:0];

  assign item.ready = (state == S_IDLE);
  assign in_acc     = item.valid && item.ready;
  assign wr_en      = in_acc && (item.operation == pipt_pkg::OP_WRITE) &&
                      ({1'b0, item.vertex_index} < (IDX_BITS + 1)'(MAX_VERTICES));

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.vertex_count > CNT_BITS'(MAX_VERTICES)) begin
        vertex_count <= CNT_BITS'(MAX_VERTICES);
      end else begin
        vertex_count <= cfg.vertex_count;
      end
    end
  end

  pipt_vertex_mem #(
    .DEPTH (MAX_VERTICES),
    .WIDTH (2 * COORD_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (item.vertex_index),
    .wr_data ({item.coord_x, item.coord_y}),
    .rd_addr (raddr),
    .rd_data (rd_data)
  );

  assign ectl.clear = in_acc;
  assign ectl.vld   = rdv;
  assign ectl.first = rdf;

  pipt_edge_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_edge (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ectl),
    .px   (px),
    .py   (py),
    .rd_x ($signed(rd_data[2*COORD_BITS-1:COORD_BITS])),
    .rd_y ($signed(rd_data[COORD_BITS-1:0])),
    .stat (estat)
  );

  // read data tags, registered so that they line up with the registered read data
  always_ff @(posedge clk) begin
    if (rst) begin
      rdv <= 1'b0;
      rdf <= 1'b0;
    end else begin
      rdv <= (state == S_RUN);
      rdf <= rfirst;
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      raddr          <= '0;
      rfirst         <= 1'b0;
      res.valid      <= 1'b0;
      res.inside_res <= 1'b0;
    end else begin
      if (res.valid && res.ready && (state != S_FIN)) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && (item.operation == pipt_pkg::OP_QUERY)) begin
            px <= item.coord_x;
            py <= item.coord_y;
            if (vertex_count == '0) begin
              state <= S_FIN;
            end else begin
              raddr  <= last_addr;
              rfirst <= 1'b1;
              state  <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (rfirst) begin
            raddr  <= '0;
            rfirst <= 1'b0;
          end else if (raddr == last_addr) begin
            state <= S_DRAIN;
          end else begin
            raddr <= raddr + IDX_BITS'(1);
          end
        end
        S_DRAIN: begin
          if (!rdv && !estat.busy) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!res.valid || res.ready) begin
            res.valid      <= 1'b1;
            res.inside_res <= estat.odd;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PIPT_ASSERT_IMP(a_run_nonempty, state == S_RUN, vertex_count != '0)
  `PIPT_ASSERT_IMP(a_run_addr_range, state == S_RUN && !rfirst, raddr <= last_addr)
  `PIPT_ASSERT_IMP(a_fin_pipe_empty, state == S_FIN, !rdv && !estat.busy)
  `PIPT_ASSERT_IMP(a_result_from_fin, $rose(res.valid), $past(state) == S_FIN)
  `PIPT_ASSERT(a_no_read_tag_idle, !(state == S_IDLE && rdv))

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// self-checking testbench of point_in_polygon_test_core with an in-bench ray casting predictor
module tb_top;

  localparam int MAX_V = pipt_pkg::MAX_VERTICES_DEF;
  localparam int ITEM_GOAL = 1100;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam real TWO_PI = 6.283185307179586;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pipt_item_if item_ch ();
  pipt_res_if  res_ch ();
  pipt_cfg_if  cfg_ch ();

  point_in_polygon_test_core i_dut (
    .clk  (clk),
    .rst  (rst),
    .item (item_ch),
    .res  (res_ch),
    .cfg  (cfg_ch)
  );

  int vert_x [MAX_V];
  int vert_y [MAX_V];
  int poly_count = 0;
  bit inside_exp_q [$];
  bit want_inside;

  int fail_count = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  int res_hold = 0;
  int rx_stall = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  int shape_x [MAX_V];
  int shape_y [MAX_V];
  int shape_cx = 0;
  int shape_cy = 0;
  int shape_rad = 10;

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // even-odd crossing count over edges (i, i-1), exact cross-multiplied compare
  function automatic bit poly_contains(input int px, input int py);
    int i, j;
    bit odd;
    longint xl, yl, xu, yu, lhs, rhs;
    odd = 1'b0;
    if (poly_count == 0) return 1'b0;
    j = poly_count - 1;
    for (i = 0; i < poly_count; i++) begin
      if (vert_y[i] <= vert_y[j]) begin
        xl = vert_x[i]; yl = vert_y[i]; xu = vert_x[j]; yu = vert_y[j];
      end else begin
        xl = vert_x[j]; yl = vert_y[j]; xu = vert_x[i]; yu = vert_y[i];
      end
      if (yl <= py && py < yu) begin
        lhs = (longint'(px) - xl) * (yu - yl);
        rhs = (xu - xl) * (longint'(py) - yl);
        if (lhs < rhs) odd = !odd;
      end
      j = i;
    end
    return odd;
  endfunction

  task automatic note_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // predictor and result check
  always @(posedge clk) begin
    if (rst) begin
      poly_count = 0;
      inside_exp_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready)
        poly_count = (cfg_ch.vertex_count > MAX_V) ? MAX_V : int'(cfg_ch.vertex_count);
      if (item_ch.valid && item_ch.ready) begin
        if (item_ch.operation == pipt_pkg::OP_WRITE) begin
          vert_x[item_ch.vertex_index] = item_ch.coord_x;
          vert_y[item_ch.vertex_index] = item_ch.coord_y;
        end else begin
          inside_exp_q.push_back(poly_contains(item_ch.coord_x, item_ch.coord_y));
        end
      end
      if (res_ch.valid && res_ch.ready) begin
        if (inside_exp_q.size() == 0) begin
          note_fail($sformatf("unexpected result word: inside_res=%0b", res_ch.inside_res));
        end else begin
          want_inside = inside_exp_q.pop_front();
          if (res_ch.inside_res !== want_inside)
            note_fail($sformatf("inside_res mismatch: expected %0b, got %0b",
                                want_inside, res_ch.inside_res));
        end
      end
    end
  end

  // result receiver with random stalls and a long hold on request
  always @(negedge clk) begin
    if (res_hold > 0) begin
      res_ch.ready <= 1'b0;
      res_hold--;
    end else if (rx_stall > 0) begin
      res_ch.ready <= 1'b0;
      rx_stall--;
    end else begin
      rx_stall = rx_calm ? 0 : pick_gap();
      if (rx_stall > 0) begin
        res_ch.ready <= 1'b0;
        rx_stall--;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("point_in_polygon_test_core regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // valid stays high after acceptance so back-to-back words need no drop
  task automatic send_word(input logic op, input logic [5:0] idx, input int x, input int y);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.operation <= op;
    item_ch.vertex_index <= idx;
    item_ch.coord_x <= 16'(x);
    item_ch.coord_y <= 16'(y);
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_vertex(input int idx, input int x, input int y);
    send_word(pipt_pkg::OP_WRITE, 6'(idx), x, y);
  endtask

  task automatic send_query(input int x, input int y);
    send_word(pipt_pkg::OP_QUERY, 6'($urandom), x, y);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (inside_exp_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_count(input logic [6:0] val);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.vertex_count <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // star-shaped polygon around a random center, small radius gives collinear runs
  task automatic build_shape(input int n);
    int k, rr;
    real ang;
    shape_cx = int'($urandom_range(0, 40000)) - 20000;
    shape_cy = int'($urandom_range(0, 40000)) - 20000;
    shape_rad = ($urandom_range(0, 1) == 1) ? int'($urandom_range(2, 40))
                                            : int'($urandom_range(41, 9000));
    for (k = 0; k < n; k++) begin
      ang = TWO_PI * (real'(k) + 0.4 * real'($urandom_range(0, 100)) / 100.0) / real'(n);
      rr = shape_rad / 3 + int'($urandom_range(0, shape_rad - shape_rad / 3));
      shape_x[k] = shape_cx + int'(real'(rr) * $cos(ang));
      shape_y[k] = shape_cy + int'(real'(rr) * $sin(ang));
      send_vertex(k, shape_x[k], shape_y[k]);
    end
  endtask

  task automatic query_near_shape(input int n);
    int pick, k, j;
    pick = $urandom_range(0, 9);
    k = (n > 0) ? int'($urandom_range(0, n - 1)) : 0;
    j = (k == 0) ? n - 1 : k - 1;
    if (n > 0 && pick == 0) begin
      send_query(shape_x[k], shape_y[k]);
    end else if (n > 0 && pick == 1) begin
      send_query((shape_x[k] + shape_x[j]) / 2, (shape_y[k] + shape_y[j]) / 2);
    end else if (n > 0 && pick == 2) begin
      send_query(shape_x[k] - int'($urandom_range(0, shape_rad)), shape_y[k]);
    end else begin
      send_query(shape_cx + int'($urandom_range(0, 2 * shape_rad + 4)) - shape_rad - 2,
                 shape_cy + int'($urandom_range(0, 2 * shape_rad + 4)) - shape_rad - 2);
    end
  endtask

  task automatic test_empty_polygon();
    send_query(-32768, -32768);
    send_query(32767, 32767);
    send_query(0, 0);
  endtask

  task automatic test_square_extremes();
    send_vertex(0, -32768, -32768);
    send_vertex(1, 32767, -32768);
    send_vertex(2, 32767, 32767);
    send_vertex(3, -32768, 32767);
    write_count(7'd4);
    send_query(0, 0);
    send_query(-32768, -32768);
    send_query(32767, 32767);
    send_query(-32768, 0);
    send_query(32767, 0);
    send_query(0, -32768);
  endtask

  // single vertex, a segment and a triangle with a flat base
  task automatic test_few_vertices();
    send_vertex(0, -100, -100);
    send_vertex(1, 100, -100);
    send_vertex(2, 0, 100);
    write_count(7'd1);
    send_query(-100, -100);
    write_count(7'd2);
    send_query(0, -100);
    write_count(7'd3);
    send_query(0, 0);
    send_query(0, -100);
    send_query(0, 100);
    send_query(-100, -100);
  endtask

  task automatic test_full_store();
    int k;
    real ang;
    shape_cx = 0;
    shape_cy = 0;
    shape_rad = 30000;
    for (k = MAX_V - 1; k >= 0; k--) begin
      ang = TWO_PI * real'(k) / real'(MAX_V);
      shape_x[k] = int'(30000.0 * $cos(ang));
      shape_y[k] = int'(30000.0 * $sin(ang));
      send_vertex(k, shape_x[k], shape_y[k]);
    end
    write_count(7'd127);
    send_query(0, 0);
    send_query(29999, 0);
    send_query(30000, 0);
    send_query(shape_x[16], shape_y[16]);
    for (k = 0; k < 4; k++) send_query(rand_coord(), rand_coord());
    write_count(7'd64);
    send_query(-29000, 100);
    send_query(32767, -32768);
  endtask

  // receiver holds off while queries keep coming, then the sender waits for all results
  task automatic test_output_stall();
    int k;
    tx_calm = 1'b1;
    res_hold = 400;
    for (k = 0; k < 5; k++) query_near_shape(MAX_V);
    send_vertex(5, shape_x[5], shape_y[5]);
    send_query(0, 0);
    tx_calm = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_phases();
    int p, c, n, r, len, start;
    p = 0;
    while (items_sent < ITEM_GOAL) begin
      case (p % 8)
        0: c = $urandom_range(0, 2);
        1: c = 3;
        2: c = $urandom_range(4, 8);
        3: c = $urandom_range(9, 24);
        4: c = $urandom_range(3, 6);
        5: c = ($urandom_range(0, 1) == 1) ? 64 : int'($urandom_range(65, 127));
        6: c = $urandom_range(4, 12);
        default: c = $urandom_range(25, 63);
      endcase
      p++;
      n = (c > MAX_V) ? MAX_V : c;
      write_count(7'(c));
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if (n > 0) build_shape(n);
      len = (n <= 16) ? 60 : 25;
      start = items_sent;
      while (items_sent - start < len) begin
        r = $urandom_range(0, 99);
        if (r < 6 && n > 0) build_shape(n);
        else if (r < 72) query_near_shape(n);
        else if (r < 84) send_query(rand_coord(), rand_coord());
        else send_vertex($urandom_range(0, MAX_V - 1), rand_coord(), rand_coord());
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin
    item_ch.valid = 1'b0;
    item_ch.operation = pipt_pkg::OP_WRITE;
    item_ch.vertex_index = '0;
    item_ch.coord_x = '0;
    item_ch.coord_y = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.vertex_count = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_polygon();
    test_square_extremes();
    test_few_vertices();
    test_full_store();
    test_output_stall();
    test_random_phases();
    wait_drained();
    repeat (MAX_V + 10) @(posedge clk);
    if (inside_exp_q.size() != 0)
      note_fail($sformatf("%0d results never arrived", inside_exp_q.size()));
    if (fail_count == 0) begin
      $display("point_in_polygon_test_core regression: pass");
    end else begin
      $display("point_in_polygon_test_core regression: fail");
    end
    $finish;
  end
endmodule
